// ===== sv/mrw_pkg.sv =====
// ---------------------------------------------------------------------------
// mrw_pkg
// Shared constants and types for the Miller-Rabin witness block.
// ---------------------------------------------------------------------------
package mrw_pkg;

    // width of the candidate, base, exponent and residue fields on the stream ports
    localparam int DATA_W = 32;

    // default datapath width
    localparam int OPERAND_BITS = 32;

    // command to the modular multiply unit
    typedef struct packed {
        logic start;   // one-cycle pulse, operands sampled with it
        logic reduce;  // 1: reduce multiplier mod modulus, 0: multiplicand*multiplier mod modulus
    } mrw_cmd_t;

endpackage

// ===== sv/mrw_mulmod.sv =====
// ---------------------------------------------------------------------------
// mrw_mulmod
// Bit-serial modular multiply / reduce unit, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module mrw_mulmod #(
    parameter int DW = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mrw_pkg::mrw_cmd_t   cmd,
    input  logic [DW-1:0]       modulus,
    input  logic [DW-1:0]       multiplicand,
    input  logic [DW-1:0]       multiplier,
    output logic                done,
    output logic [DW-1:0]       result
);

    localparam int CntW = $clog2(DW + 1);

    logic [DW-1:0]   r_reg,      r_next;
    logic [DW-1:0]   md_reg,     md_next;
    logic [DW-1:0]   mr_reg,     mr_next;
    logic            reduce_reg, reduce_next;
    logic            busy_reg,   busy_next;
    logic            done_reg,   done_next;
    logic [CntW-1:0] cnt_reg,    cnt_next;

    logic [DW-1:0]   addend;
    logic [DW+1:0]   sum;
    logic [DW+1:0]   mod_x1;
    logic [DW+1:0]   mod_x2;
    logic [DW+1:0]   red;

    // 2r + addend < 3n, so at most two moduli come off
    always_comb
    begin
        if (reduce_reg)
        begin
            addend = {{(DW-1){1'b0}}, mr_reg[DW-1]};
        end
        else
        begin
            addend = mr_reg[DW-1] ? md_reg : '0;
        end
        sum    = {1'b0, r_reg, 1'b0} + {2'b00, addend};
        mod_x1 = {2'b00, modulus};
        mod_x2 = {1'b0, modulus, 1'b0};
        if (sum >= mod_x2)
        begin
            red = sum - mod_x2;
        end
        else if (sum >= mod_x1)
        begin
            red = sum - mod_x1;
        end
        else
        begin
            red = sum;
        end
    end

    always_comb
    begin
        r_next      = r_reg;
        md_next     = md_reg;
        mr_next     = mr_reg;
        reduce_next = reduce_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        if (cmd.start)
        begin
            r_next      = '0;
            md_next     = multiplicand;
            mr_next     = multiplier;
            reduce_next = cmd.reduce;
            busy_next   = 1'b1;
            cnt_next    = CntW'(DW);
        end
        else if (busy_reg)
        begin
            r_next   = red[DW-1:0];
            mr_next  = {mr_reg[DW-2:0], 1'b0};
            cnt_next = cnt_reg - CntW'(1);
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg      <= r_next;
        md_reg     <= md_next;
        mr_reg     <= mr_next;
        reduce_reg <= reduce_next;
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

// ===== sv/miller_rabin_witness.sv =====
// ---------------------------------------------------------------------------
// miller_rabin_witness
// Miller-Rabin witness: base^exponent mod candidate with square-root-of-one
// and zero checks, built on one bit-serial modular multiply unit.
// ---------------------------------------------------------------------------
// Sequence: candidates below 4 are answered directly. Otherwise the unit first
//   reduces the base, then per exponent bit squares the accumulator and, when
//   the bit is set, multiplies by the base; both passes are skipped while the
//   accumulator is 1 (DW = min(OPERAND_BITS, 32)).
// Throughput: one item at a time; the multiply unit sets the pace.
// Reset: rst_n (async, active low) clears the sequencer and the output valid.
// ---------------------------------------------------------------------------
module miller_rabin_witness #(
    parameter int OPERAND_BITS = mrw_pkg::OPERAND_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // candidate[31:0], base[63:32], exponent[95:64]
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // residue[31:0], probable_prime[32], zero[39:33]
);

    localparam int DataW = mrw_pkg::DATA_W;
    // inputs are 32 bits wide, so a wider datapath only scans zero bits
    localparam int DW    = (OPERAND_BITS < DataW) ? OPERAND_BITS : DataW;
    localparam int KW    = $clog2(DW + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_STEP,
        ST_SQUARE,
        ST_MULT,
        ST_FIN
    } state_t;

    state_t              state_reg,  state_next;
    logic [DW-1:0]       n_reg,      n_next;      // modulus
    logic [DW-1:0]       a_reg,      a_next;      // base, later base mod n
    logic [DW-1:0]       e_reg,      e_next;      // exponent, msb is current bit
    logic [KW-1:0]       k_reg,      k_next;      // exponent bits left
    logic [DW-1:0]       acc_reg,    acc_next;
    logic [DW-1:0]       x_reg,      x_next;      // accumulator before squaring
    logic [DW-1:0]       res_reg,    res_next;    // final residue
    mrw_pkg::mrw_cmd_t   cmd_reg,    cmd_next;
    logic [DW-1:0]       opa_reg,    opa_next;
    logic [DW-1:0]       opb_reg,    opb_next;
    logic                ovalid_reg, ovalid_next;
    logic [DataW-1:0]    ores_reg,   ores_next;
    logic                oprime_reg, oprime_next;

    logic                in_xfer;
    logic [DW-1:0]       in_cand;
    logic                mm_done;
    logic [DW-1:0]       mm_result;
    logic                nontrivial;

    assign in_xfer = s_tvalid && s_tready;
    assign in_cand = s_tdata[DW-1:0];

    // square of 1 from a root other than 1 or n-1 marks a composite
    assign nontrivial = (mm_result == DW'(1)) && (x_reg != DW'(1))
                        && (x_reg != (n_reg - DW'(1)));

    mrw_mulmod #(
        .DW (DW)
    ) u_mulmod (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd_reg),
        .modulus      (n_reg),
        .multiplicand (opa_reg),
        .multiplier   (opb_reg),
        .done         (mm_done),
        .result       (mm_result)
    );

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        a_next      = a_reg;
        e_next      = e_reg;
        k_next      = k_reg;
        acc_next    = acc_reg;
        x_next      = x_reg;
        res_next    = res_reg;
        cmd_next    = '0;
        opa_next    = opa_reg;
        opb_next    = opb_reg;
        ovalid_next = ovalid_reg;
        ores_next   = ores_reg;
        oprime_next = oprime_reg;

        // output register frees up on a completed transfer
        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    n_next = in_cand;
                    a_next = s_tdata[DataW+DW-1:DataW];
                    e_next = s_tdata[2*DataW+DW-1:2*DataW];
                    if (in_cand == DW'(2) || in_cand == DW'(3))
                    begin
                        res_next   = DW'(1);
                        state_next = ST_FIN;
                    end
                    else if (in_cand < DW'(4))
                    begin
                        res_next   = '0;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        // base mod n: restoring reduction in the shared unit
                        cmd_next.start  = 1'b1;
                        cmd_next.reduce = 1'b1;
                        opb_next        = s_tdata[DataW+DW-1:DataW];
                        state_next      = ST_REDUCE;
                    end
                end
            end

            ST_REDUCE:
            begin
                if (mm_done)
                begin
                    a_next     = mm_result;
                    acc_next   = DW'(1);
                    k_next     = KW'(DW);
                    state_next = ST_STEP;
                end
            end

            ST_STEP:
            begin
                x_next = acc_reg;
                if (acc_reg == '0)
                begin
                    res_next   = '0;
                    state_next = ST_FIN;
                end
                else if (k_reg == '0)
                begin
                    res_next   = acc_reg;
                    state_next = ST_FIN;
                end
                else if (acc_reg == DW'(1))
                begin
                    // 1 squared is 1, and a*1 is a: no unit pass needed
                    acc_next = e_reg[DW-1] ? a_reg : DW'(1);
                    e_next   = {e_reg[DW-2:0], 1'b0};
                    k_next   = k_reg - KW'(1);
                end
                else
                begin
                    cmd_next.start = 1'b1;
                    opa_next       = acc_reg;
                    opb_next       = acc_reg;
                    state_next     = ST_SQUARE;
                end
            end

            ST_SQUARE:
            begin
                if (mm_done)
                begin
                    if (nontrivial)
                    begin
                        res_next   = '0;
                        state_next = ST_FIN;
                    end
                    else if (e_reg[DW-1])
                    begin
                        cmd_next.start = 1'b1;
                        opa_next       = a_reg;
                        opb_next       = mm_result;
                        state_next     = ST_MULT;
                    end
                    else
                    begin
                        acc_next   = mm_result;
                        e_next     = {e_reg[DW-2:0], 1'b0};
                        k_next     = k_reg - KW'(1);
                        state_next = ST_STEP;
                    end
                end
            end

            ST_MULT:
            begin
                if (mm_done)
                begin
                    acc_next   = mm_result;
                    e_next     = {e_reg[DW-2:0], 1'b0};
                    k_next     = k_reg - KW'(1);
                    state_next = ST_STEP;
                end
            end

            ST_FIN:
            begin
                // wait for the output register to be free
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    ores_next   = DataW'(res_reg);
                    oprime_next = (res_reg == DW'(1));
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cmd_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        a_reg      <= a_next;
        e_reg      <= e_next;
        k_reg      <= k_next;
        acc_reg    <= acc_next;
        x_reg      <= x_next;
        res_reg    <= res_next;
        opa_reg    <= opa_next;
        opb_reg    <= opb_next;
        ores_reg   <= ores_next;
        oprime_reg <= oprime_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {7'b0, oprime_reg, ores_reg};

endmodule

// ===== tb/tb_miller_rabin_witness.sv =====
// ---------------------------------------------------------------------------
// tb_miller_rabin_witness
// Self-checking bench for the Miller-Rabin witness block. Each input transfer
// is scored against a modular-exponentiation predictor; results are checked
// in order. Directed corner items first, then random items dominated by
// well-formed witness tests (prime, Carmichael and random odd candidates)
// with random idling on both streams and one long output back-pressure.
// ---------------------------------------------------------------------------
module tb_miller_rabin_witness;

    localparam int OP_BITS      = mrw_pkg::OPERAND_BITS;
    localparam int RANDOM_ITEMS = 730;
    localparam int HOLD_CYCLES  = 6000;        // longer than the slowest item
    localparam int TAIL_CYCLES  = 2400;        // longer than the worst-case item latency
    localparam int CYCLE_LIMIT  = 8_000_000;

    // result layout on m_tdata, lowest field last
    typedef struct packed {
        logic [6:0]  pad;
        logic        probable_prime;
        logic [31:0] residue;
    } witness_result_t;

    // -----------------------------------------------------------------------
    // Scoreboard: predicts each witness result and matches them in order
    // -----------------------------------------------------------------------
    class witness_scoreboard;
        witness_result_t results_due[$];
        int              faults;

        function new();
            faults = 0;
        endfunction

        // base^exponent mod candidate with zero and nontrivial-root checks
        function witness_result_t predict_witness(bit [31:0] cand, bit [31:0] wbase,
                                                  bit [31:0] expo);
            longint unsigned mask;
            longint unsigned n;
            longint unsigned a;
            longint unsigned e;
            longint unsigned acc;
            longint unsigned x;
            longint unsigned y;
            witness_result_t r;
            int              k;
            mask = (OP_BITS >= 32) ? 64'hFFFF_FFFF : ((64'd1 << OP_BITS) - 1);
            n    = cand & mask;
            a    = wbase & mask;
            e    = expo & mask;
            if (n == 2 || n == 3)
                acc = 1;
            else if (n < 4)
                acc = 0;
            else
            begin
                a   = a % n;
                acc = 1;
                for (k = 31; k >= 0; k--)
                begin
                    x = acc;
                    if (x == 0)
                        break;
                    y = (x * x) % n;              // operands < 2^32, product fits
                    if (y == 1 && x != 1 && x != n - 1)
                    begin
                        acc = 0;                  // nontrivial square root of one
                        break;
                    end
                    if (e[k])
                        y = (a * y) % n;
                    acc = y;
                end
            end
            r                = '0;
            r.residue        = acc[31:0];
            r.probable_prime = (acc == 1);
            return r;
        endfunction

        function void note_transfer_in(bit [31:0] cand, bit [31:0] wbase, bit [31:0] expo);
            results_due.push_back(predict_witness(cand, wbase, expo));
        endfunction

        function void check_transfer_out(witness_result_t got);
            witness_result_t want;
            if (results_due.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result: residue %h prime %b", got.residue,
                             got.probable_prime);
                return;
            end
            want = results_due.pop_front();
            if (got.residue !== want.residue || got.probable_prime !== want.probable_prime
                || got.pad !== '0)
            begin
                faults++;
                if (faults <= 10)
                    $display("mismatch: residue exp %h got %h, prime exp %b got %b, pad got %h",
                             want.residue, got.residue, want.probable_prime,
                             got.probable_prime, got.pad);
            end
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // Signals and DUT
    // -----------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;    // candidate[31:0], base[63:32], exponent[95:64]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // residue[31:0], probable_prime[32], zero[39:33]

    witness_scoreboard sb;
    bit                idling;        // random gaps on both sides while set
    bit                hold_request;  // sender asks the receiver for a long hold-off
    int unsigned       cycles;

    miller_rabin_witness dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("tb_miller_rabin_witness: errors");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: ready changes at the falling edge; random stalls, plus one
    // long hold-off on request so the block backs up and drops s_tready
    // -----------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready = 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES - 1;
                m_tready     = 1'b0;
            end
            else if (idling && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 6) - 1;
                m_tready   = 1'b0;
            end
            else
                m_tready = 1'b1;
        end
    end

    // output monitor: sample at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_transfer_out(witness_result_t'(m_tdata));
    end

    // -----------------------------------------------------------------------
    // Sender tasks
    // -----------------------------------------------------------------------

    // one input transfer; inputs change on the falling edge only
    task automatic send_item(input bit [31:0] cand, input bit [31:0] wbase,
                             input bit [31:0] expo);
        int gap;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
        end
        s_tdata  = {expo, wbase, cand};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_transfer_in(cand, wbase, expo);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // returns on a falling edge so the next item starts there
    task automatic wait_for_drain();
        while (sb.results_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // mostly well-formed witness tests, some broken items and noise
    task automatic send_random_item();
        bit [31:0] n;
        bit [31:0] a;
        bit [31:0] e;
        bit [31:0] d;
        bit        found;
        int        kind;
        int        pick;
        kind = $urandom_range(0, 99);
        a    = $urandom;
        if (kind < 35)
        begin
            // prime candidate, mostly small so items stay short
            found = 1'b0;
            while (!found)
            begin
                if ($urandom_range(0, 9) < 7)
                    n = $urandom_range(2, 32767) * 2 + 1;
                else
                    n = ($urandom & 32'h0FFF_FFFF) | 32'd1;
                found = (n > 4);
                for (d = 3; found && d * d <= n; d += 2)
                    if (n % d == 0)
                        found = 1'b0;
            end
        end
        else if (kind < 60)
            n = $urandom | 32'd1;
        else if (kind < 75)
        begin
            pick = $urandom_range(0, 6);
            case (pick)
                0:       n = 561;
                1:       n = 1105;
                2:       n = 1729;
                3:       n = 2465;
                4:       n = 2821;
                5:       n = 6601;
                default: n = 8911;
            endcase
        end
        else if (kind < 85)
            n = $urandom_range(0, 7);
        else
            n = $urandom;

        if (kind < 75)
        begin
            if (n > 4 && $urandom_range(0, 4) == 0)
                a = $urandom_range(2, n - 2);
            // exponent n-1, or its odd part d so residues like n-1 show up
            e = n - 1;
            if ($urandom_range(0, 3) == 0)
                while (e != 0 && !e[0])
                    e = e >> 1;
        end
        else
            e = $urandom;
        send_item(n, a, e);
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial
    begin
        int i;
        sb           = new();
        idling       = 1'b1;
        hold_request = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed corners
        send_item(32'd0, $urandom, $urandom);                       // candidate zero
        send_item(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);             // candidate one
        send_item(32'd2, $urandom, $urandom);                       // candidate two
        send_item(32'd3, 32'd0, 32'd0);                             // candidate three
        send_item(32'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'd4, 32'd3, 32'd3);                             // smallest full path
        send_item(32'd4, 32'd2, 32'd3);                             // zero intermediate
        send_item(32'd97, 32'd5, 32'd0);                            // exponent zero
        send_item(32'd97, 32'd97, 32'd96);                          // base == candidate
        send_item(32'd97, 32'd0, 32'd96);                           // base zero
        send_item(32'd97, 32'd194, 32'd5);                          // base multiple
        send_item(32'd97, 32'd5, 32'd1);                            // leading zero bits
        send_item(32'hFFFF_FFFB, 32'd2, 32'hFFFF_FFFA);             // largest 32-bit prime
        send_item(32'hFFFF_FFFB, 32'hFFFF_FFFF, 32'hFFFF_FFFA);
        send_item(32'd561, 32'd2, 32'd560);                         // Carmichael, bad root
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);     // all ones
        send_item(32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFE);
        send_item(32'd5, 32'd4, 32'd2);                             // root n-1 allowed
        send_item(32'd15, 32'd4, 32'd2);                            // nontrivial root
        send_item(32'd8, 32'd3, 32'd2);                             // even candidate
        send_item(32'h7FFF_FFFF, 32'd3, 32'h7FFF_FFFE);             // Mersenne prime
        send_item(32'hFFFF_FFFF, 32'd0, 32'd0);

        // sender pause until every result is back
        wait_for_drain();

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 150)
                hold_request = 1'b1;        // long back-pressure while items keep coming
            if (i == 400)
                wait_for_drain();
            if (i == RANDOM_ITEMS - 100)
                idling = 1'b0;              // closing stretch at full rate
            send_random_item();
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.faults == 0 && sb.results_due.size() == 0)
            $display("tb_miller_rabin_witness: clean");
        else
            $display("tb_miller_rabin_witness: errors");
        $finish;
    end

endmodule
